// ----- rtl/ovfm_pkg.sv -----
// ----------------------------------------------------------------------------
// ovfm_pkg
// Shared codes and types of the over-voltage fault monitor: event kinds,
// register indexes, fault kinds and the status word passed between stages.
// ----------------------------------------------------------------------------
`default_nettype none

package ovfm_pkg;

   // event kinds carried in the func field
   localparam int unsigned FUNC_BITS = 3;
   localparam logic [FUNC_BITS-1:0] EV_SAMPLE = 3'd0;
   localparam logic [FUNC_BITS-1:0] EV_TICK   = 3'd1;
   localparam logic [FUNC_BITS-1:0] EV_START  = 3'd2;
   localparam logic [FUNC_BITS-1:0] EV_STOP   = 3'd3;
   localparam logic [FUNC_BITS-1:0] EV_RESET  = 3'd4;

   // configuration register indexes
   localparam int unsigned CSR_INDEX_BITS = 2;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_INSTANT_TRIP_LEVEL = 2'd0;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_DELAYED_TRIP_LEVEL = 2'd1;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_LIMITS_VALID       = 2'd2;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_ERROR_DELAY_TICKS  = 2'd3;

   // fault kinds
   localparam logic FAULT_EMERGENCY = 1'b0;
   localparam logic FAULT_ERROR     = 1'b1;

   // per-event status flags that go with each result word
   typedef struct packed {
      logic fault_raised;
      logic fault_kind;
      logic is_running;
      logic is_latched;
      logic is_armed;
   } status_type;

endpackage

`default_nettype wire

// ----- rtl/ovfm_if.sv -----
// ----------------------------------------------------------------------------
// ovfm_req_if / ovfm_rsp_if
// Valid/ready channels of the over-voltage fault monitor: event words in,
// status words out.
// ----------------------------------------------------------------------------
`default_nettype none

interface ovfm_req_if #(
   parameter int unsigned VOLT_BITS = 17
);
   logic                                valid;
   logic                                ready;
   logic [ovfm_pkg::FUNC_BITS-1:0]      func;
   logic [VOLT_BITS-1:0]                voltage;

   modport source (output valid, output func, output voltage, input ready);
   modport sink   (input valid, input func, input voltage, output ready);
endinterface

interface ovfm_rsp_if #(
   parameter int unsigned VOLT_BITS = 17
);
   logic                 valid;
   logic                 ready;
   logic                 fault_raised;
   logic                 fault_kind;
   logic [VOLT_BITS-1:0] fault_voltage;
   logic                 is_running;
   logic                 is_latched;
   logic                 is_armed;

   modport source (
      output valid, output fault_raised, output fault_kind, output fault_voltage,
      output is_running, output is_latched, output is_armed, input ready
   );
   modport sink (
      input valid, input fault_raised, input fault_kind, input fault_voltage,
      input is_running, input is_latched, input is_armed, output ready
   );
endinterface

`default_nettype wire

// ----- rtl/ovfm_csr.sv -----
// ----------------------------------------------------------------------------
// ovfm_csr
// Configuration registers: trip levels, limits-valid flag and error delay.
// ----------------------------------------------------------------------------
`default_nettype none

module ovfm_csr #(
   parameter int unsigned VOLT_BITS  = 17,
   parameter int unsigned DELAY_BITS = 16,
   parameter int unsigned DATA_BITS  = 17
) (
   input  wire logic                                clock,
   input  wire logic                                reset,
   input  wire logic                                csr_we,
   input  wire logic [ovfm_pkg::CSR_INDEX_BITS-1:0] csr_index,
   input  wire logic [DATA_BITS-1:0]                csr_wdata,
   output logic [VOLT_BITS-1:0]                     instant_trip_level,
   output logic [VOLT_BITS-1:0]                     delayed_trip_level,
   output logic                                     limits_valid,
   output logic [DELAY_BITS-1:0]                    error_delay_ticks
);

   logic [VOLT_BITS-1:0]  instant_trip_level_ff;
   logic [VOLT_BITS-1:0]  delayed_trip_level_ff;
   logic                  limits_valid_ff;
   logic [DELAY_BITS-1:0] error_delay_ff;

   // register writes, decoded by index
   always_ff @(posedge clock) begin
      if (reset) begin
         instant_trip_level_ff <= {VOLT_BITS{1'b1}};
         delayed_trip_level_ff <= {VOLT_BITS{1'b1}};
         limits_valid_ff       <= 1'b0;
         error_delay_ff        <= '0;
      end else if (csr_we) begin
         unique case (csr_index)
            ovfm_pkg::CSR_INSTANT_TRIP_LEVEL: instant_trip_level_ff <= csr_wdata[VOLT_BITS-1:0];
            ovfm_pkg::CSR_DELAYED_TRIP_LEVEL: delayed_trip_level_ff <= csr_wdata[VOLT_BITS-1:0];
            ovfm_pkg::CSR_LIMITS_VALID:       limits_valid_ff       <= csr_wdata[0];
            ovfm_pkg::CSR_ERROR_DELAY_TICKS:  error_delay_ff        <= csr_wdata[DELAY_BITS-1:0];
            default: ;
         endcase
      end
   end

   assign instant_trip_level = instant_trip_level_ff;
   assign delayed_trip_level = delayed_trip_level_ff;
   assign limits_valid       = limits_valid_ff;
   assign error_delay_ticks  = error_delay_ff;

endmodule

`default_nettype wire

// ----- rtl/ovfm_core.sv -----
// ----------------------------------------------------------------------------
// ovfm_core
// Monitor state and the per-event decision: trip compares, delay counter,
// peak tracking and fault latch. State commits when fire is high.
// ----------------------------------------------------------------------------
`default_nettype none

module ovfm_core #(
   parameter int unsigned VOLT_BITS  = 17,
   parameter int unsigned DELAY_BITS = 16
) (
   input  wire logic                           clock,
   input  wire logic                           reset,
   input  wire logic                           fire,
   input  wire logic [ovfm_pkg::FUNC_BITS-1:0] func,
   input  wire logic [VOLT_BITS-1:0]           voltage,
   input  wire logic [VOLT_BITS-1:0]           instant_trip_level,
   input  wire logic [VOLT_BITS-1:0]           delayed_trip_level,
   input  wire logic                           limits_valid,
   input  wire logic [DELAY_BITS-1:0]          error_delay_ticks,
   output ovfm_pkg::status_type                status,
   output logic [VOLT_BITS-1:0]                fault_voltage
);

   logic                  running_ff, running_in;
   logic                  latched_ff, latched_in;
   logic                  armed_ff, armed_in;
   logic [VOLT_BITS-1:0]  peak_ff, peak_in;
   logic [DELAY_BITS-1:0] ticks_ff, ticks_in;

   logic                  trip;
   logic                  trip_kind;
   logic [VOLT_BITS-1:0]  trip_volt;
   logic                  sampling;

   assign sampling = running_ff && !latched_ff && limits_valid;

   // next state for the event at hand
   always_comb begin
      running_in = running_ff;
      latched_in = latched_ff;
      armed_in   = armed_ff;
      peak_in    = peak_ff;
      ticks_in   = ticks_ff;
      trip       = 1'b0;
      trip_kind  = ovfm_pkg::FAULT_EMERGENCY;
      trip_volt  = '0;
      case (func)
         ovfm_pkg::EV_SAMPLE: begin
            if (sampling) begin
               if (voltage >= instant_trip_level) begin
                  trip      = 1'b1;
                  trip_kind = ovfm_pkg::FAULT_EMERGENCY;
                  trip_volt = voltage;
               end else if (voltage >= delayed_trip_level) begin
                  if (error_delay_ticks == '0) begin
                     trip      = 1'b1;
                     trip_kind = ovfm_pkg::FAULT_ERROR;
                     trip_volt = voltage;
                  end else if (armed_ff) begin
                     if (voltage > peak_ff) begin
                        peak_in = voltage;
                     end
                  end else begin
                     armed_in = 1'b1;
                     peak_in  = voltage;
                     ticks_in = error_delay_ticks;
                  end
               end else begin
                  armed_in = 1'b0;
               end
            end
         end
         ovfm_pkg::EV_TICK: begin
            if (armed_ff) begin
               if (ticks_ff <= DELAY_BITS'(1)) begin
                  ticks_in  = '0;
                  trip      = 1'b1;
                  trip_kind = ovfm_pkg::FAULT_ERROR;
                  trip_volt = peak_ff;
               end else begin
                  ticks_in = ticks_ff - DELAY_BITS'(1);
               end
            end
         end
         ovfm_pkg::EV_START: begin
            latched_in = 1'b0;
            armed_in   = 1'b0;
            running_in = 1'b1;
         end
         ovfm_pkg::EV_STOP: begin
            running_in = 1'b0;
            armed_in   = 1'b0;
         end
         ovfm_pkg::EV_RESET: begin
            latched_in = 1'b0;
            armed_in   = 1'b0;
         end
         default: ;
      endcase
      // any fault latches and stops monitoring
      if (trip) begin
         latched_in = 1'b1;
         running_in = 1'b0;
         armed_in   = 1'b0;
      end
   end

   // control state
   always_ff @(posedge clock) begin
      if (reset) begin
         running_ff <= 1'b0;
         latched_ff <= 1'b0;
         armed_ff   <= 1'b0;
         peak_ff    <= '0;
         ticks_ff   <= '0;
      end else if (fire) begin
         running_ff <= running_in;
         latched_ff <= latched_in;
         armed_ff   <= armed_in;
         peak_ff    <= peak_in;
         ticks_ff   <= ticks_in;
      end
   end

   // result for this event
   always_comb begin
      status.fault_raised = trip;
      status.fault_kind   = trip_kind;
      status.is_running   = running_in;
      status.is_latched   = latched_in;
      status.is_armed     = armed_in;
   end
   assign fault_voltage = trip_volt;

   // the counter is only ever armed while monitoring runs
   a_armed_running: assert property (@(posedge clock) disable iff (reset)
      armed_ff |-> (running_ff && !latched_ff))
      else $error("delay counter armed while monitor not running");

   // running and latched exclude each other
   a_run_latch: assert property (@(posedge clock) disable iff (reset)
      !(running_ff && latched_ff))
      else $error("monitor running with a fault latched");

   // a non-expiring tick counts down by one
   a_tick_count: assert property (@(posedge clock) disable iff (reset)
      (fire && func == ovfm_pkg::EV_TICK && armed_ff && ticks_ff > DELAY_BITS'(1))
      |=> (armed_ff && ticks_ff == DELAY_BITS'($past(ticks_ff) - DELAY_BITS'(1))))
      else $error("delay counter did not decrement on tick");

   // a fault leaves the monitor latched and stopped
   a_fault_latch: assert property (@(posedge clock) disable iff (reset)
      (fire && trip) |=> (latched_ff && !running_ff && !armed_ff))
      else $error("fault did not latch");

endmodule

`default_nettype wire

// ----- rtl/over_voltage_fault_monitor_unit.sv -----
// ----------------------------------------------------------------------------
// over_voltage_fault_monitor_unit
// Two-level over-voltage trip with delayed error fault, valid/ready top level.
// ----------------------------------------------------------------------------
// Each event word (sample, tick, start, stop, reset) on req returns exactly one
// status word on rsp: it passes through the input register and then the
// output register, and is held there while rsp is stalled. One event is
// accepted every cycle while rsp is not stalled: the event is registered,
// evaluated against the monitor state by a single level of compares and the
// delay-counter decrement, and the result lands in an output register; the
// monitor state commits in the same cycle, so back-to-back events see each
// other's effect. Configuration writes on the csr port take effect on the
// next cycle and are meant to be made while no event is in flight.
// ----------------------------------------------------------------------------
`default_nettype none

module over_voltage_fault_monitor_unit #(
   parameter int unsigned VOLT_BITS  = 17,
   parameter int unsigned DELAY_BITS = 16
) (
   input  wire logic                                clock,
   input  wire logic                                reset,
   ovfm_req_if.sink                                 req,
   ovfm_rsp_if.source                               rsp,
   input  wire logic                                csr_we,
   input  wire logic [ovfm_pkg::CSR_INDEX_BITS-1:0] csr_index,
   input  wire logic [((VOLT_BITS > DELAY_BITS) ? VOLT_BITS : DELAY_BITS)-1:0] csr_wdata
);

   localparam int unsigned DATA_BITS = (VOLT_BITS > DELAY_BITS) ? VOLT_BITS : DELAY_BITS;

   logic [VOLT_BITS-1:0]  instant_trip_level;
   logic [VOLT_BITS-1:0]  delayed_trip_level;
   logic                  limits_valid;
   logic [DELAY_BITS-1:0] error_delay_ticks;

   // input register
   logic                           in_valid_ff;
   logic [ovfm_pkg::FUNC_BITS-1:0] in_func_ff;
   logic [VOLT_BITS-1:0]           in_voltage_ff;

   // output register
   logic                 out_valid_ff;
   ovfm_pkg::status_type out_status_ff;
   logic [VOLT_BITS-1:0] out_voltage_ff;

   ovfm_pkg::status_type status;
   logic [VOLT_BITS-1:0] fault_voltage;
   logic                 out_free;
   logic                 advance;
   logic                 req_take;

   // pipeline flow control
   assign out_free = !out_valid_ff || rsp.ready;
   assign advance  = in_valid_ff && out_free;
   assign req.ready = !in_valid_ff || advance;
   assign req_take  = req.valid && req.ready;

   ovfm_csr #(
      .VOLT_BITS (VOLT_BITS),
      .DELAY_BITS(DELAY_BITS),
      .DATA_BITS (DATA_BITS)
   ) u_csr (
      .clock             (clock),
      .reset             (reset),
      .csr_we            (csr_we),
      .csr_index         (csr_index),
      .csr_wdata         (csr_wdata),
      .instant_trip_level(instant_trip_level),
      .delayed_trip_level(delayed_trip_level),
      .limits_valid      (limits_valid),
      .error_delay_ticks (error_delay_ticks)
   );

   ovfm_core #(
      .VOLT_BITS (VOLT_BITS),
      .DELAY_BITS(DELAY_BITS)
   ) u_core (
      .clock             (clock),
      .reset             (reset),
      .fire              (advance),
      .func              (in_func_ff),
      .voltage           (in_voltage_ff),
      .instant_trip_level(instant_trip_level),
      .delayed_trip_level(delayed_trip_level),
      .limits_valid      (limits_valid),
      .error_delay_ticks (error_delay_ticks),
      .status            (status),
      .fault_voltage     (fault_voltage)
   );

   // input stage
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (req.ready) begin
         in_valid_ff <= req.valid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_take) begin
         in_func_ff    <= req.func;
         in_voltage_ff <= req.voltage;
      end
   end

   // output stage
   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (out_free) begin
         out_valid_ff <= in_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         out_status_ff  <= status;
         out_voltage_ff <= fault_voltage;
      end
   end

   assign rsp.valid         = out_valid_ff;
   assign rsp.fault_raised  = out_status_ff.fault_raised;
   assign rsp.fault_kind    = out_status_ff.fault_kind;
   assign rsp.fault_voltage = out_voltage_ff;
   assign rsp.is_running    = out_status_ff.is_running;
   assign rsp.is_latched    = out_status_ff.is_latched;
   assign rsp.is_armed      = out_status_ff.is_armed;

   // a held input word is never overwritten by a new one
   a_no_overrun: assert property (@(posedge clock) disable iff (reset)
      (in_valid_ff && !out_free) |-> !req.ready)
      else $error("input register overwritten while stalled");

   // an evaluated word always reaches the output register
   a_advance_out: assert property (@(posedge clock) disable iff (reset)
      advance |=> out_valid_ff)
      else $error("evaluated word lost before output");

   // a stalled result holds its fault fields
   a_out_hold: assert property (@(posedge clock) disable iff (reset)
      (out_valid_ff && !rsp.ready) |=> ($stable(out_status_ff) && $stable(out_voltage_ff)))
      else $error("stalled result changed");

endmodule

`default_nettype wire
